FILE: rtl/page_table_frame_allocator_defines.svh
// Assertion macros for the page table frame allocator checker.
// Expects clk_i and rst_ni in the scope where a macro is used.
`ifndef PAGE_TABLE_FRAME_ALLOCATOR_DEFINES_SVH
`define PAGE_TABLE_FRAME_ALLOCATOR_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define PTFA_ASSERT_SAME(lbl, ant, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ant) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define PTFA_ASSERT_NEXT(lbl, ant, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ant) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/ptfa_pkg.sv
// Shared widths, codes and types of the page table frame allocator.
// No dependencies; used by the interfaces, the top level and the checker.
package ptfa_pkg;

  localparam int unsigned MODE_W      = 2;
  localparam int unsigned OPERAND_W   = 32;
  localparam int unsigned REND_W      = 6;
  localparam int unsigned STATUS_W    = 3;
  localparam int unsigned PAGE_NUM_W  = 8;
  localparam int unsigned FRAME_NUM_W = 6;
  localparam int unsigned PADDR_W     = 32;
  localparam int unsigned OFFSET_W    = 5;
  localparam int unsigned VBITS_W     = 6;
  localparam int unsigned PBITS_W     = 6;
  localparam int unsigned CFG_IDX_W   = 2;
  localparam int unsigned CFG_DATA_W  = 6;

  // Widest address the translate path handles.
  localparam logic [VBITS_W-1:0] ADDR_BITS_MAX = 6'd32;
  // Pages mapped at most before a shortfall flag closes an allocation.
  localparam logic [31:0] MAX_MAPPED_ON_SHORTFALL = 32'd63;

  localparam logic [OFFSET_W-1:0] OFFSET_BITS_RST   = 5'd12;
  localparam logic [VBITS_W-1:0]  VIRTUAL_BITS_RST  = 6'd20;
  localparam logic [PBITS_W-1:0]  PHYSICAL_BITS_RST = 6'd18;

  typedef enum logic [MODE_W-1:0] {
    MODE_ALLOCATE  = 2'd0,
    MODE_TRANSLATE = 2'd1,
    MODE_DELETE    = 2'd2,
    MODE_RESERVE   = 2'd3
  } mode_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_MAPPED       = 3'd0,
    ST_TRANSLATED   = 3'd1,
    ST_INVALID_PAGE = 3'd2,
    ST_DELETED      = 3'd3,
    ST_NO_FRAMES    = 3'd4,
    ST_NO_PAGES     = 3'd5,
    ST_RESERVED     = 3'd6,
    ST_EMPTY        = 3'd7
  } status_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_OFFSET_BITS   = 2'd0,
    CFG_VIRTUAL_BITS  = 2'd1,
    CFG_PHYSICAL_BITS = 2'd2
  } cfg_reg_e;

endpackage

FILE: rtl/ptfa_if.sv
// Valid/ready channel interfaces: request items, result items, config writes.
// Depends on ptfa_pkg for field widths.
interface ptfa_in_if;
  logic                                valid;
  logic                                ready;
  logic [ptfa_pkg::MODE_W-1:0]         mode;
  logic [ptfa_pkg::OPERAND_W-1:0]      operand_value;
  logic [ptfa_pkg::REND_W-1:0]         range_end;

  modport source (output valid, mode, operand_value, range_end, input ready);
  modport sink (input valid, mode, operand_value, range_end, output ready);
endinterface

interface ptfa_out_if;
  logic                                valid;
  logic                                ready;
  logic [ptfa_pkg::STATUS_W-1:0]       status;
  logic [ptfa_pkg::PAGE_NUM_W-1:0]     page_number;
  logic [ptfa_pkg::FRAME_NUM_W-1:0]    frame_number;
  logic [ptfa_pkg::PADDR_W-1:0]        physical_address;
  logic                                last_result;

  modport source (output valid, status, page_number, frame_number, physical_address,
                  last_result, input ready);
  modport sink (input valid, status, page_number, frame_number, physical_address,
                last_result, output ready);
endinterface

interface ptfa_cfg_if;
  logic                                valid;
  logic                                ready;
  logic [ptfa_pkg::CFG_IDX_W-1:0]      index;
  logic [ptfa_pkg::CFG_DATA_W-1:0]     data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

FILE: rtl/ptfa_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module ptfa_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/page_table_frame_allocator.sv
// Page table frame allocator: frame busy bitmap, page table RAM, next page counter.
// Depends on ptfa_pkg, ptfa_if.sv (channel interfaces) and ptfa_ram.
//
//   channel | dir | beat carries
//   --------+-----+------------------------------------------------------------
//   cfg_i   | in  | register index, write data (always ready)
//   in_i    | in  | mode, operand_value, range_end
//   out_o   | out | status, page_number, frame_number, physical_address, last
//
// Allocate: the frame sweep counter walks the busy bitmap once to count free frames
// and once to pick them; translate and delete pass through the page table RAM read;
// reserve walks the bitmap once. Output stalls hold up the mapping beats and the
// reply. in_i is ready only between items; a finished result may still wait in the
// output register while the next item enters.
// Reset: no clearing pass; a page entry counts only below the next page counter.
module page_table_frame_allocator #(
  parameter int unsigned FRAME_COUNT = 64,
  parameter int unsigned PAGE_COUNT  = 256
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  ptfa_cfg_if.sink       cfg_i,
  ptfa_in_if.sink        in_i,
  ptfa_out_if.source     out_o
);

  localparam int unsigned FW = $clog2(FRAME_COUNT);
  localparam int unsigned CW = $clog2(FRAME_COUNT + 1);
  localparam int unsigned PW = $clog2(PAGE_COUNT);
  localparam int unsigned NW = $clog2(PAGE_COUNT + 1);
  localparam int unsigned RW = ptfa_pkg::FRAME_NUM_W + 1;
  localparam logic [FW-1:0] FRAME_LAST = FW'(FRAME_COUNT - 1);

  typedef enum logic [8:0] {
    S_IDLE    = 9'b000000001,
    S_DECODE  = 9'b000000010,
    S_COUNT   = 9'b000000100,
    S_PLAN    = 9'b000001000,
    S_ALLOC   = 9'b000010000,
    S_RESERVE = 9'b000100000,
    S_READ    = 9'b001000000,
    S_RESOLVE = 9'b010000000,
    S_REPLY   = 9'b100000000
  } state_e;

  function automatic logic [31:0] low_mask(input logic [5:0] n);
    low_mask = (n >= 6'd32) ? 32'hFFFF_FFFF : ~(32'hFFFF_FFFF << n);
  endfunction

  // Control state
  state_e                          state_q, state_d;
  logic [ptfa_pkg::OFFSET_W-1:0]   off_q, off_d;
  logic [ptfa_pkg::VBITS_W-1:0]    virt_q, virt_d;
  logic [ptfa_pkg::PBITS_W-1:0]    phys_q, phys_d;
  logic [FRAME_COUNT-1:0]          busy_q, busy_d;
  logic [NW-1:0]                   next_page_q, next_page_d;
  logic [FW-1:0]                   idx_q, idx_d;
  logic [CW-1:0]                   free_q, free_d;
  logic [CW-1:0]                   k_q, k_d;
  logic [CW-1:0]                   n_q, n_d;
  logic                            fail_q, fail_d;
  logic                            lack_frames_q, lack_frames_d;
  logic                            o_valid_q, o_valid_d;

  // Payload
  logic [ptfa_pkg::MODE_W-1:0]     mode_q, mode_d;
  logic [ptfa_pkg::OPERAND_W-1:0]  opd_q, opd_d;
  logic [ptfa_pkg::REND_W-1:0]     rend_q, rend_d;
  logic [31:0]                     req_q, req_d;
  logic [31:0]                     pg_q, pg_d;
  logic [ptfa_pkg::STATUS_W-1:0]   rs_status_q, rs_status_d;
  logic [ptfa_pkg::PAGE_NUM_W-1:0] rs_page_q, rs_page_d;
  logic [ptfa_pkg::FRAME_NUM_W-1:0] rs_frame_q, rs_frame_d;
  logic [ptfa_pkg::PADDR_W-1:0]    rs_pa_q, rs_pa_d;
  logic [ptfa_pkg::STATUS_W-1:0]   o_status_q, o_status_d;
  logic [ptfa_pkg::PAGE_NUM_W-1:0] o_page_q, o_page_d;
  logic [ptfa_pkg::FRAME_NUM_W-1:0] o_frame_q, o_frame_d;
  logic [ptfa_pkg::PADDR_W-1:0]    o_pa_q, o_pa_d;
  logic                            o_last_q, o_last_d;

  // Page table RAM: {valid, frame}
  logic                            ram_we;
  logic [PW-1:0]                   ram_waddr;
  logic [RW-1:0]                   ram_wdata;
  logic [RW-1:0]                   ram_rdata;

  // Datapath helpers
  logic                            out_free;
  logic [31:0]                     np32;
  logic [31:0]                     req_shift;
  logic [5:0]                      f6;
  logic [5:0]                      v6;
  logic [5:0]                      p6;
  logic [31:0]                     xlate_page;
  logic [31:0]                     xlate_pa;
  logic [ptfa_pkg::FRAME_NUM_W-1:0] rd_frame;
  logic                            hit;
  logic [31:0]                     free32;
  logic [31:0]                     left32;
  logic [31:0]                     avail32;
  logic [31:0]                     n32;
  logic                            plan_fail;

  ptfa_ram #(
    .WIDTH (RW),
    .DEPTH (PAGE_COUNT)
  ) u_page_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (pg_q[PW-1:0]),
    .rdata_o (ram_rdata)
  );

  assign out_free  = !o_valid_q || out_o.ready;
  assign np32      = 32'(next_page_q);
  assign req_shift = opd_q >> off_q;
  assign f6        = {1'b0, off_q};
  assign v6        = (virt_q > ptfa_pkg::ADDR_BITS_MAX) ? ptfa_pkg::ADDR_BITS_MAX : virt_q;
  assign p6        = (phys_q > ptfa_pkg::ADDR_BITS_MAX) ? ptfa_pkg::ADDR_BITS_MAX : phys_q;
  assign xlate_page = (v6 > f6) ? ((opd_q >> off_q) & low_mask(v6 - f6)) : 32'd0;
  assign rd_frame  = ram_rdata[ptfa_pkg::FRAME_NUM_W-1:0];
  assign hit       = (pg_q < np32) && ram_rdata[RW-1];
  assign xlate_pa  = (opd_q & low_mask(f6)) |
                     ((p6 > f6) ? ((32'(rd_frame) & low_mask(p6 - f6)) << off_q) : 32'd0);
  assign free32    = 32'(free_q);
  assign left32    = 32'(PAGE_COUNT) - np32;
  assign avail32   = (free32 < left32) ? free32 : left32;
  assign plan_fail = req_q > avail32;
  assign n32       = plan_fail ? ((avail32 > ptfa_pkg::MAX_MAPPED_ON_SHORTFALL) ?
                                  ptfa_pkg::MAX_MAPPED_ON_SHORTFALL : avail32)
                               : req_q;

  always_comb begin
    state_d       = state_q;
    off_d         = off_q;
    virt_d        = virt_q;
    phys_d        = phys_q;
    busy_d        = busy_q;
    next_page_d   = next_page_q;
    idx_d         = idx_q;
    free_d        = free_q;
    k_d           = k_q;
    n_d           = n_q;
    fail_d        = fail_q;
    lack_frames_d = lack_frames_q;
    o_valid_d     = o_valid_q;
    mode_d        = mode_q;
    opd_d         = opd_q;
    rend_d        = rend_q;
    req_d         = req_q;
    pg_d          = pg_q;
    rs_status_d   = rs_status_q;
    rs_page_d     = rs_page_q;
    rs_frame_d    = rs_frame_q;
    rs_pa_d       = rs_pa_q;
    o_status_d    = o_status_q;
    o_page_d      = o_page_q;
    o_frame_d     = o_frame_q;
    o_pa_d        = o_pa_q;
    o_last_d      = o_last_q;
    ram_we        = 1'b0;
    ram_waddr     = next_page_q[PW-1:0];
    ram_wdata     = {1'b1, ptfa_pkg::FRAME_NUM_W'(idx_q)};

    // Drop the result once its beat is taken.
    if (o_valid_q && out_o.ready) begin
      o_valid_d = 1'b0;
    end

    if (cfg_i.valid) begin
      case (ptfa_pkg::cfg_reg_e'(cfg_i.index))
        ptfa_pkg::CFG_OFFSET_BITS:   off_d  = cfg_i.data[ptfa_pkg::OFFSET_W-1:0];
        ptfa_pkg::CFG_VIRTUAL_BITS:  virt_d = cfg_i.data;
        ptfa_pkg::CFG_PHYSICAL_BITS: phys_d = cfg_i.data;
        default: ;
      endcase
    end

    case (state_q)
      S_IDLE: begin
        if (in_i.valid) begin
          mode_d  = in_i.mode;
          opd_d   = in_i.operand_value;
          rend_d  = in_i.range_end;
          state_d = S_DECODE;
        end
      end

      S_DECODE: begin
        req_d  = req_shift;
        idx_d  = '0;
        free_d = '0;
        k_d    = '0;
        case (ptfa_pkg::mode_e'(mode_q))
          ptfa_pkg::MODE_ALLOCATE: begin
            if (req_shift == 32'd0) begin
              rs_status_d = ptfa_pkg::ST_EMPTY;
              rs_page_d   = np32[ptfa_pkg::PAGE_NUM_W-1:0];
              rs_frame_d  = '0;
              rs_pa_d     = '0;
              state_d     = S_REPLY;
            end else begin
              state_d = S_COUNT;
            end
          end
          ptfa_pkg::MODE_TRANSLATE: begin
            pg_d    = xlate_page;
            state_d = S_READ;
          end
          ptfa_pkg::MODE_DELETE: begin
            pg_d    = opd_q;
            state_d = S_READ;
          end
          ptfa_pkg::MODE_RESERVE: begin
            rs_status_d = ptfa_pkg::ST_RESERVED;
            rs_page_d   = '0;
            rs_frame_d  = rend_q;
            rs_pa_d     = '0;
            state_d     = S_RESERVE;
          end
          default: state_d = S_IDLE;
        endcase
      end

      S_COUNT: begin
        if (!busy_q[idx_q]) begin
          free_d = free_q + CW'(1);
        end
        if (idx_q == FRAME_LAST) begin
          state_d = S_PLAN;
        end else begin
          idx_d = idx_q + FW'(1);
        end
      end

      S_PLAN: begin
        fail_d        = plan_fail;
        lack_frames_d = free32 <= left32;
        n_d           = CW'(n32);
        idx_d         = '0;
        state_d       = S_ALLOC;
      end

      S_ALLOC: begin
        if (k_q == n_q) begin
          if (fail_q) begin
            rs_status_d = lack_frames_q ? ptfa_pkg::ST_NO_FRAMES : ptfa_pkg::ST_NO_PAGES;
            rs_page_d   = np32[ptfa_pkg::PAGE_NUM_W-1:0];
            rs_frame_d  = '0;
            rs_pa_d     = '0;
            state_d     = S_REPLY;
          end else begin
            state_d = S_IDLE;
          end
        end else if (busy_q[idx_q]) begin
          idx_d = idx_q + FW'(1);
        end else if (out_free) begin
          // Map the next page to this free frame and emit its beat.
          busy_d[idx_q] = 1'b1;
          ram_we        = 1'b1;
          o_valid_d     = 1'b1;
          o_status_d    = ptfa_pkg::ST_MAPPED;
          o_page_d      = np32[ptfa_pkg::PAGE_NUM_W-1:0];
          o_frame_d     = ptfa_pkg::FRAME_NUM_W'(idx_q);
          o_pa_d        = '0;
          o_last_d      = !fail_q && ((k_q + CW'(1)) == n_q);
          next_page_d   = next_page_q + NW'(1);
          k_d           = k_q + CW'(1);
          idx_d         = idx_q + FW'(1);
        end
      end

      S_RESERVE: begin
        if ((32'(idx_q) >= opd_q) && (ptfa_pkg::REND_W'(idx_q) <= rend_q)) begin
          busy_d[idx_q] = 1'b1;
        end
        if (idx_q == FRAME_LAST) begin
          state_d = S_REPLY;
        end else begin
          idx_d = idx_q + FW'(1);
        end
      end

      S_READ: begin
        state_d = S_RESOLVE;
      end

      S_RESOLVE: begin
        rs_page_d  = pg_q[ptfa_pkg::PAGE_NUM_W-1:0];
        rs_frame_d = '0;
        rs_pa_d    = '0;
        if (!hit) begin
          rs_status_d = ptfa_pkg::ST_INVALID_PAGE;
        end else if (mode_q == ptfa_pkg::MODE_TRANSLATE) begin
          rs_status_d = ptfa_pkg::ST_TRANSLATED;
          rs_frame_d  = rd_frame;
          rs_pa_d     = xlate_pa;
        end else begin
          rs_status_d = ptfa_pkg::ST_DELETED;
          rs_frame_d  = rd_frame;
          if (32'(rd_frame) < 32'(FRAME_COUNT)) begin
            busy_d[rd_frame[FW-1:0]] = 1'b0;
          end
          ram_we    = 1'b1;
          ram_waddr = pg_q[PW-1:0];
          ram_wdata = {1'b0, rd_frame};
        end
        state_d = S_REPLY;
      end

      S_REPLY: begin
        if (out_free) begin
          o_valid_d  = 1'b1;
          o_status_d = rs_status_q;
          o_page_d   = rs_page_q;
          o_frame_d  = rs_frame_q;
          o_pa_d     = rs_pa_q;
          o_last_d   = 1'b1;
          state_d    = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      off_q         <= ptfa_pkg::OFFSET_BITS_RST;
      virt_q        <= ptfa_pkg::VIRTUAL_BITS_RST;
      phys_q        <= ptfa_pkg::PHYSICAL_BITS_RST;
      busy_q        <= '0;
      next_page_q   <= '0;
      idx_q         <= '0;
      free_q        <= '0;
      k_q           <= '0;
      n_q           <= '0;
      fail_q        <= 1'b0;
      lack_frames_q <= 1'b0;
      o_valid_q     <= 1'b0;
    end else begin
      state_q       <= state_d;
      off_q         <= off_d;
      virt_q        <= virt_d;
      phys_q        <= phys_d;
      busy_q        <= busy_d;
      next_page_q   <= next_page_d;
      idx_q         <= idx_d;
      free_q        <= free_d;
      k_q           <= k_d;
      n_q           <= n_d;
      fail_q        <= fail_d;
      lack_frames_q <= lack_frames_d;
      o_valid_q     <= o_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mode_q      <= mode_d;
    opd_q       <= opd_d;
    rend_q      <= rend_d;
    req_q       <= req_d;
    pg_q        <= pg_d;
    rs_status_q <= rs_status_d;
    rs_page_q   <= rs_page_d;
    rs_frame_q  <= rs_frame_d;
    rs_pa_q     <= rs_pa_d;
    o_status_q  <= o_status_d;
    o_page_q    <= o_page_d;
    o_frame_q   <= o_frame_d;
    o_pa_q      <= o_pa_d;
    o_last_q    <= o_last_d;
  end

  assign cfg_i.ready            = 1'b1;
  assign in_i.ready             = (state_q == S_IDLE);
  assign out_o.valid            = o_valid_q;
  assign out_o.status           = o_status_q;
  assign out_o.page_number      = o_page_q;
  assign out_o.frame_number     = o_frame_q;
  assign out_o.physical_address = o_pa_q;
  assign out_o.last_result      = o_last_q;

endmodule

FILE: rtl/ptfa_checker.sv
// Port-level checks of the page table frame allocator, bound to the top level.
// Depends on ptfa_pkg and page_table_frame_allocator_defines.svh.
`include "page_table_frame_allocator_defines.svh"

module ptfa_checker (
  input logic                                 clk_i,
  input logic                                 rst_ni,
  input logic                                 in_valid_i,
  input logic                                 in_ready_i,
  input logic                                 out_valid_i,
  input logic                                 out_ready_i,
  input logic [ptfa_pkg::STATUS_W-1:0]        out_status_i,
  input logic [ptfa_pkg::PAGE_NUM_W-1:0]      out_page_i,
  input logic [ptfa_pkg::FRAME_NUM_W-1:0]     out_frame_i,
  input logic [ptfa_pkg::PADDR_W-1:0]         out_paddr_i,
  input logic                                 out_last_i
);

  // A stalled result beat holds.
  `PTFA_ASSERT_NEXT(a_out_hold, out_valid_i && !out_ready_i, out_valid_i && $stable(out_status_i) && $stable(out_page_i) && $stable(out_frame_i) && $stable(out_paddr_i) && $stable(out_last_i), "stalled result changed")

  // Only page mappings may be followed by more results of the same item.
  `PTFA_ASSERT_SAME(a_nonlast_mapped, out_valid_i && !out_last_i, out_status_i == ptfa_pkg::ST_MAPPED, "non-final result is not a mapping")

  // Address is zero unless the result is a translation.
  `PTFA_ASSERT_SAME(a_pa_only_xlate, out_valid_i && (out_status_i != ptfa_pkg::ST_TRANSLATED), out_paddr_i == '0, "address set on non-translate result")

  // Flags carry no frame.
  `PTFA_ASSERT_SAME(a_flag_no_frame, out_valid_i && ((out_status_i == ptfa_pkg::ST_NO_FRAMES) || (out_status_i == ptfa_pkg::ST_NO_PAGES) || (out_status_i == ptfa_pkg::ST_EMPTY) || (out_status_i == ptfa_pkg::ST_INVALID_PAGE)), out_frame_i == '0, "flag result carries a frame")

  // One item at a time: accepting an item closes the request side.
  `PTFA_ASSERT_NEXT(a_one_item, in_valid_i && in_ready_i, !in_ready_i, "ready stayed high after accept")

endmodule

bind page_table_frame_allocator ptfa_checker u_ptfa_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_i.valid),
  .in_ready_i   (in_i.ready),
  .out_valid_i  (out_o.valid),
  .out_ready_i  (out_o.ready),
  .out_status_i (out_o.status),
  .out_page_i   (out_o.page_number),
  .out_frame_i  (out_o.frame_number),
  .out_paddr_i  (out_o.physical_address),
  .out_last_i   (out_o.last_result)
);
